FILE: rtl/core/assert_macros.svh
// assertion macros shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression that must never hold
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

FILE: rtl/core/mpdt_pkg.sv
// types and constants of the median pair distance threshold core
package mpdt_pkg;

	localparam int COORD_W    = 16;
	localparam int TAU_W      = 16;
	localparam int DIMS_W     = 4;
	localparam int THR_W      = 32;
	localparam int STAT_W     = 2;
	localparam int DIST_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TAU_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 2'd1;

	localparam logic [TAU_W-1:0]  TAU_RESET  = 16'd256;
	localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd2;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FEW  = 2'd1,
		STAT_MANY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_value;
		logic                      last_point;
	} item_t;

	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

FILE: rtl/core/mpdt_isqrt.sv
// iterative integer square root, two radicand bits per cycle
module mpdt_isqrt #(
	parameter int W = 36
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   radicand,
	output logic           done,
	output logic [W/2-1:0] root
);
	localparam logic [W-1:0] TOP_BIT = W'(1) << (W - 2);

	logic [W-1:0] v_q;
	logic [W-1:0] r_q;
	logic [W-1:0] bit_q;
	logic         run_q;
	logic         done_q;
	logic [W-1:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q   <= radicand;
				r_q   <= '0;
				bit_q <= TOP_BIT;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = r_q[W/2-1:0];

endmodule

FILE: rtl/core/median_pairwise_distance_threshold_core.sv
// top level of the median pair distance threshold core
//
// Points are loaded one coordinate per request on the start/busy channel: a request is
// taken at a clock edge with start high and busy low. Each point has dims_in_use
// coordinates; last_point marks the final coordinate of the set and closes it.
// Coordinate requests that do not close the set leave busy low.
// After the closing request busy stays high while the core walks every point pair
// of each group: S_PAIR_RD, S_PAIR_SQ and S_PAIR_ACC for each coordinate, then the
// shared square root unit per pair, then a radix selection that scans the stored
// distances once per result bit (24 passes, two medians for an even count).
// An error case (too many or fewer than two points) is answered from the S_CHECK
// state, entered on the closing request. The result is shown for one cycle with
// result_valid high; the receiver cannot stall it. cfg_ready is low while busy, so
// registers change only while idle, also while a point set is still being loaded.
// Reset clears the point count, the coordinate index, the overflow flag and the control
// state, and sets tau_gain to 256 and dims_in_use to 2. The point and distance memories
// need no clearing pass: a stored point length masks coordinates that were not loaded.
`include "assert_macros.svh"

module median_pairwise_distance_threshold_core #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_DIMS   = 8,
	parameter int PART_LIMIT = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  mpdt_pkg::item_t                     item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpdt_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                result_valid,
	output mpdt_pkg::result_t                   result
);
	import mpdt_pkg::*;

	localparam int PA         = $clog2(MAX_POINTS);
	localparam int PC_W       = $clog2(MAX_POINTS + 1);
	localparam int DIM_AW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DW         = $clog2(MAX_DIMS + 1);
	localparam int GMAX       = (MAX_POINTS < PART_LIMIT) ? MAX_POINTS : PART_LIMIT;
	localparam int DIST_DEPTH = GMAX * (GMAX - 1) / 2;
	localparam int DIST_AW    = (DIST_DEPTH > 1) ? $clog2(DIST_DEPTH) : 1;
	localparam int MED_DEPTH  = (MAX_POINTS + PART_LIMIT) / PART_LIMIT + 1;
	localparam int MED_AW     = $clog2(MED_DEPTH);
	localparam int MW         = $clog2(MED_DEPTH + 1);
	localparam int KMAX       = (DIST_DEPTH > MED_DEPTH) ? DIST_DEPTH : MED_DEPTH;
	localparam int KW         = $clog2(KMAX + 1);
	localparam int CNT_W      = $clog2(2 * MAX_POINTS + PART_LIMIT + 2);
	localparam int SUM_W      = ((32 + DIM_AW + 1) / 2) * 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int PROD_W     = TAU_W + DIST_W;

	typedef enum logic [12:0] {
		S_IDLE     = 13'h0001,
		S_CHECK    = 13'h0002,
		S_DIV_P    = 13'h0004,
		S_DIV_S    = 13'h0008,
		S_GRP      = 13'h0010,
		S_PAIR_RD  = 13'h0020,
		S_PAIR_SQ  = 13'h0040,
		S_PAIR_ACC = 13'h0080,
		S_SQRT     = 13'h0100,
		S_SEL_INIT = 13'h0200,
		S_SEL_SCAN = 13'h0400,
		S_SEL_DONE = 13'h0800,
		S_MUL      = 13'h1000
	} state_t;

	state_t state_q;

	logic [TAU_W-1:0]  tau_q;
	logic [DIMS_W-1:0] dims_q;
	logic [PC_W-1:0]   pc_q;
	logic [DIM_AW-1:0] ci_q;
	logic              ovf_q;
	logic              ovf_res_q;
	logic [CNT_W-1:0]  n_q;

	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  quo_q;
	logic [CNT_W-1:0]  parts_q;
	logic [CNT_W-1:0]  size_q;
	logic [CNT_W-1:0]  gi_q;
	logic [CNT_W-1:0]  gstart_q;
	logic [CNT_W-1:0]  gstop_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [MW-1:0]     m_q;
	logic [DW-1:0]     c_q;
	logic [31:0]       sq_q;
	logic [SUM_W-1:0]  sum_q;

	logic [KW-1:0]     k_q;
	logic [KW-1:0]     idx_q;
	logic [KW-1:0]     cnt_q;
	logic [KW-1:0]     rank_q;
	logic [DIST_W-1:0] prefix_q;
	logic [DIST_W-1:0] mask_q;
	logic [DIST_W-1:0] bitsel_q;
	logic [DIST_W-1:0] lo_q;
	logic [DIST_W-1:0] med_q;
	logic              first_q;
	logic              sel_gm_q;
	logic              rd_valid_s1;
	logic [PROD_W-1:0] prod_c;

	logic              res_valid_q;
	logic [THR_W-1:0]  res_thr_q;
	logic [STAT_W-1:0] res_stat_q;

	logic [COORD_W-1:0] pt_mem [MAX_POINTS * (2 ** DIM_AW)];
	logic [DW-1:0]      len_mem [MAX_POINTS];
	logic [DIST_W-1:0]  dist_mem [DIST_DEPTH];
	logic [DIST_W-1:0]  gm_mem [MED_DEPTH];

	logic [COORD_W-1:0] pa_rd_s1;
	logic [COORD_W-1:0] pb_rd_s1;
	logic [DW-1:0]      la_rd_s1;
	logic [DW-1:0]      lb_rd_s1;
	logic [DIST_W-1:0]  dist_rd_s1;
	logic [DIST_W-1:0]  gm_rd_s1;

	logic                accept;
	logic                pc_room;
	logic [DW-1:0]       dims_eff;
	logic [DW-1:0]       ci_next1;
	logic                close;
	logic [CNT_W-1:0]    gend;
	logic [CNT_W-1:0]    gstop_c;
	logic [COORD_W-1:0]  ca;
	logic [COORD_W-1:0]  cb;
	logic signed [16:0]  diff;
	logic signed [33:0]  sq_c;
	logic                sqrt_start;
	logic [SUM_W-1:0]    radicand;
	logic                sqrt_done;
	logic [ROOT_W-1:0]   sqrt_root;
	logic [DIST_W-1:0]   sv;
	logic                match;
	logic                pass_end;
	logic [DIST_W-1:0]   med_c;
	logic                dist_we;
	logic                gm_we;
	logic                need_hi;

	always_comb begin
		if (dims_q == '0) begin
			dims_eff = DW'(1);
		end else if (int'(dims_q) > MAX_DIMS) begin
			dims_eff = DW'(MAX_DIMS);
		end else begin
			dims_eff = DW'(dims_q);
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign pc_room   = (pc_q < PC_W'(MAX_POINTS));
	assign ci_next1  = DW'(ci_q) + DW'(1);
	assign close     = item.last_point || (ci_next1 >= dims_eff);

	assign gend    = gstart_q + size_q;
	assign gstop_c = (gend > n_q) ? n_q : gend;

	assign ca   = (la_rd_s1 > c_q) ? pa_rd_s1 : '0;
	assign cb   = (lb_rd_s1 > c_q) ? pb_rd_s1 : '0;
	assign diff = $signed({ca[COORD_W-1], ca}) - $signed({cb[COORD_W-1], cb});
	assign sq_c = diff * diff;

	assign sqrt_start = (state_q == S_PAIR_ACC) && (c_q + DW'(1) == dims_eff);
	assign radicand   = sum_q + SUM_W'(sq_q);

	assign sv       = sel_gm_q ? gm_rd_s1 : dist_rd_s1;
	assign match    = (((sv ^ prefix_q) & mask_q) == '0) && ((sv & bitsel_q) == '0);
	assign pass_end = (state_q == S_SEL_SCAN) && (idx_q == k_q) && !rd_valid_s1;
	assign need_hi  = !k_q[0] && first_q;
	assign med_c    = k_q[0] ? prefix_q
		: DIST_W'(({1'b0, lo_q} + {1'b0, prefix_q}) >> 1);

	assign dist_we = (state_q == S_SQRT) && sqrt_done;
	assign gm_we   = (state_q == S_SEL_DONE) && !need_hi && !sel_gm_q;
	assign prod_c  = PROD_W'(tau_q) * PROD_W'(med_q);

	mpdt_isqrt #(
		.W (SUM_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk) begin
		if (accept && pc_room) begin
			pt_mem[{pc_q[PA-1:0], ci_q}] <= item.coord_value;
			if (close) begin
				len_mem[pc_q[PA-1:0]] <= ci_next1;
			end
		end
		pa_rd_s1 <= pt_mem[{i_q[PA-1:0], c_q[DIM_AW-1:0]}];
		pb_rd_s1 <= pt_mem[{j_q[PA-1:0], c_q[DIM_AW-1:0]}];
		la_rd_s1 <= len_mem[i_q[PA-1:0]];
		lb_rd_s1 <= len_mem[j_q[PA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[k_q[DIST_AW-1:0]] <= DIST_W'(sqrt_root);
		end
		if (gm_we) begin
			gm_mem[m_q[MED_AW-1:0]] <= med_c;
		end
		dist_rd_s1 <= dist_mem[idx_q[DIST_AW-1:0]];
		gm_rd_s1   <= gm_mem[idx_q[MED_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tau_q       <= TAU_RESET;
			dims_q      <= DIMS_RESET;
			pc_q        <= '0;
			ci_q        <= '0;
			ovf_q       <= 1'b0;
			ovf_res_q   <= 1'b0;
			n_q         <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			quo_q       <= '0;
			parts_q     <= '0;
			size_q      <= '0;
			gi_q        <= '0;
			gstart_q    <= '0;
			gstop_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			m_q         <= '0;
			c_q         <= '0;
			sq_q        <= '0;
			sum_q       <= '0;
			k_q         <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			rank_q      <= '0;
			prefix_q    <= '0;
			mask_q      <= '0;
			bitsel_q    <= '0;
			lo_q        <= '0;
			med_q       <= '0;
			first_q     <= 1'b0;
			sel_gm_q    <= 1'b0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			res_thr_q   <= '0;
			res_stat_q  <= '0;
		end else begin
			res_valid_q <= (state_q == S_MUL)
				|| ((state_q == S_CHECK) && (ovf_res_q || (n_q < CNT_W'(2))));
			rd_valid_s1 <= (state_q == S_SEL_SCAN) && (idx_q != k_q);

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TAU_GAIN:    tau_q  <= cfg_data[TAU_W-1:0];
					CFG_DIMS_IN_USE: dims_q <= cfg_data[DIMS_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				if (item.last_point) begin
					n_q       <= pc_room ? CNT_W'(pc_q) + CNT_W'(1) : CNT_W'(pc_q);
					ovf_res_q <= ovf_q || !pc_room;
					pc_q      <= '0;
					ci_q      <= '0;
					ovf_q     <= 1'b0;
					state_q   <= S_CHECK;
				end else begin
					if (!pc_room) begin
						ovf_q <= 1'b1;
					end
					if (close) begin
						ci_q <= '0;
						if (pc_room) begin
							pc_q <= pc_q + PC_W'(1);
						end
					end else begin
						ci_q <= ci_q + DIM_AW'(1);
					end
				end
			end

			unique case (state_q)
				S_IDLE: ;
				S_CHECK: begin
					if (ovf_res_q) begin
						res_thr_q   <= '0;
						res_stat_q  <= STAT_MANY;
						state_q     <= S_IDLE;
					end else if (n_q < CNT_W'(2)) begin
						res_thr_q   <= '0;
						res_stat_q  <= STAT_FEW;
						state_q     <= S_IDLE;
					end else if (n_q <= CNT_W'(PART_LIMIT)) begin
						parts_q  <= CNT_W'(1);
						size_q   <= n_q;
						gi_q     <= '0;
						gstart_q <= '0;
						m_q      <= '0;
						state_q  <= S_GRP;
					end else begin
						rem_q   <= n_q + CNT_W'(PART_LIMIT);
						den_q   <= CNT_W'(PART_LIMIT);
						quo_q   <= '0;
						state_q <= S_DIV_P;
					end
				end
				S_DIV_P: begin
					if (rem_q >= den_q) begin
						rem_q <= rem_q - den_q;
						quo_q <= quo_q + CNT_W'(1);
					end else begin
						parts_q <= quo_q;
						rem_q   <= n_q;
						den_q   <= quo_q;
						quo_q   <= '0;
						state_q <= S_DIV_S;
					end
				end
				S_DIV_S: begin
					if (rem_q >= den_q) begin
						rem_q <= rem_q - den_q;
						quo_q <= quo_q + CNT_W'(1);
					end else begin
						size_q   <= quo_q + CNT_W'(1);
						gi_q     <= '0;
						gstart_q <= '0;
						m_q      <= '0;
						state_q  <= S_GRP;
					end
				end
				S_GRP: begin
					if (gi_q == parts_q) begin
						if (m_q == '0) begin
							med_q   <= '0;
							state_q <= S_MUL;
						end else begin
							k_q      <= KW'(m_q);
							sel_gm_q <= 1'b1;
							state_q  <= S_SEL_INIT;
						end
					end else if (gstop_c > gstart_q + CNT_W'(1)) begin
						i_q      <= gstart_q + CNT_W'(1);
						j_q      <= gstart_q;
						gstop_q  <= gstop_c;
						k_q      <= '0;
						c_q      <= '0;
						sum_q    <= '0;
						sel_gm_q <= 1'b0;
						state_q  <= S_PAIR_RD;
					end else begin
						gi_q     <= gi_q + CNT_W'(1);
						gstart_q <= gend;
					end
				end
				S_PAIR_RD: state_q <= S_PAIR_SQ;
				S_PAIR_SQ: begin
					sq_q    <= sq_c[31:0];
					state_q <= S_PAIR_ACC;
				end
				S_PAIR_ACC: begin
					sum_q <= radicand;
					if (sqrt_start) begin
						state_q <= S_SQRT;
					end else begin
						c_q     <= c_q + DW'(1);
						state_q <= S_PAIR_RD;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						k_q   <= k_q + KW'(1);
						c_q   <= '0;
						sum_q <= '0;
						if (j_q + CNT_W'(1) == i_q) begin
							if (i_q + CNT_W'(1) == gstop_q) begin
								state_q <= S_SEL_INIT;
							end else begin
								i_q     <= i_q + CNT_W'(1);
								j_q     <= gstart_q;
								state_q <= S_PAIR_RD;
							end
						end else begin
							j_q     <= j_q + CNT_W'(1);
							state_q <= S_PAIR_RD;
						end
					end
				end
				S_SEL_INIT: begin
					rank_q   <= k_q[0] ? (k_q >> 1) : (k_q >> 1) - KW'(1);
					first_q  <= 1'b1;
					prefix_q <= '0;
					mask_q   <= '0;
					bitsel_q <= DIST_W'(1) << (DIST_W - 1);
					idx_q    <= '0;
					cnt_q    <= '0;
					state_q  <= S_SEL_SCAN;
				end
				S_SEL_SCAN: begin
					if (idx_q != k_q) begin
						idx_q <= idx_q + KW'(1);
					end
					if (rd_valid_s1 && match) begin
						cnt_q <= cnt_q + KW'(1);
					end
					if (pass_end) begin
						if (rank_q >= cnt_q) begin
							prefix_q <= prefix_q | bitsel_q;
							rank_q   <= rank_q - cnt_q;
						end
						mask_q   <= mask_q | bitsel_q;
						bitsel_q <= bitsel_q >> 1;
						idx_q    <= '0;
						cnt_q    <= '0;
						if (bitsel_q[0]) begin
							state_q <= S_SEL_DONE;
						end
					end
				end
				S_SEL_DONE: begin
					if (need_hi) begin
						lo_q     <= prefix_q;
						first_q  <= 1'b0;
						rank_q   <= k_q >> 1;
						prefix_q <= '0;
						mask_q   <= '0;
						bitsel_q <= DIST_W'(1) << (DIST_W - 1);
						idx_q    <= '0;
						cnt_q    <= '0;
						state_q  <= S_SEL_SCAN;
					end else if (sel_gm_q) begin
						med_q   <= med_c;
						state_q <= S_MUL;
					end else begin
						m_q      <= m_q + MW'(1);
						gi_q     <= gi_q + CNT_W'(1);
						gstart_q <= gend;
						state_q  <= S_GRP;
					end
				end
				S_MUL: begin
					first_q     <= 1'b1;
					sel_gm_q    <= 1'b0;
					state_q     <= S_IDLE;
					res_stat_q  <= STAT_OK;
					res_thr_q   <= ((prod_c >> THR_W) != '0) ? '1 : prod_c[THR_W-1:0];
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid     = res_valid_q;
	assign result.threshold = res_thr_q;
	assign result.status    = res_stat_q;

	`ASSERT_CLK(a_result_one_cycle, result_valid |=> !result_valid,
		"result strobe held longer than one cycle")
	`ASSERT_CLK(a_error_zero, result_valid && result.status != STAT_OK |-> result.threshold == '0,
		"error result carries a nonzero threshold")
	`ASSERT_CLK(a_result_after_work, result_valid |-> $past(busy),
		"result without a closed point set")

endmodule

FILE: tb/median_pairwise_distance_threshold_core_tb.sv
// self-checking testbench of the median pair distance threshold core
`timescale 1ns / 1ps

module median_pairwise_distance_threshold_core_tb;
	import mpdt_pkg::*;

	localparam int NPTS   = 64;
	localparam int NDIMS  = 8;
	localparam int PLIMIT = 16;
	localparam int NITEMS = 1900;

	typedef struct packed {
		logic [COORD_W-1:0] coord;
		logic               last;
		logic               typed;
		logic [THR_W-1:0]   thr;
		status_t            stat;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_valid;
	result_t               result;

	// predictor state
	logic [COORD_W-1:0] pts [NPTS][NDIMS];
	logic [31:0]        work [256];
	logic [31:0]        grp_med [8];
	int                 npoints;
	int                 cidx;
	bit                 ovf;
	logic [TAU_W-1:0]   tau_reg;
	logic [DIMS_W-1:0]  dims_reg;

	result_t pending_results [$];
	bit      typed_valid;
	result_t typed_res;
	row_t    rows [$];

	int errors;
	int items_sent;
	int sets_sent;
	int few_sets;
	int many_sets;
	int results_seen;
	int idle_pct;

	median_pairwise_distance_threshold_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic logic [31:0] pair_dist(input int a, input int b, input int dims);
		logic [63:0] sum;
		longint      d;
		sum = 0;
		for (int c = 0; c < dims; c++) begin
			d = longint'($signed(pts[a][c])) - longint'($signed(pts[b][c]));
			sum = sum + 64'(d * d);
		end
		return int_sqrt(sum);
	endfunction

	// sorts work[0..n-1] and returns its median
	function automatic logic [31:0] work_median(input int n);
		logic [31:0] t;
		logic [32:0] s;
		int          j;
		for (int i = 1; i < n; i++) begin
			t = work[i];
			j = i - 1;
			while (j >= 0 && work[j] > t) begin
				work[j+1] = work[j];
				j--;
			end
			work[j+1] = t;
		end
		if (n % 2)
			return work[n/2];
		s = {1'b0, work[n/2-1]} + {1'b0, work[n/2]};
		return s[32:1];
	endfunction

	function automatic logic [31:0] group_median(input int lo, input int hi, input int dims);
		int k;
		k = 0;
		for (int i = lo; i < hi; i++)
			for (int j = lo; j < i; j++) begin
				work[k] = pair_dist(i, j, dims);
				k++;
			end
		return work_median(k);
	endfunction

	task automatic predict_coord(input logic [COORD_W-1:0] v, input logic last);
		int          dims;
		int          parts;
		int          gsize;
		int          m;
		int          lo;
		int          hi;
		logic [31:0] med;
		logic [63:0] prod;
		result_t     r;
		dims = (dims_reg == 0) ? 1 : (dims_reg > NDIMS) ? NDIMS : dims_reg;
		if (npoints < NPTS) begin
			if (cidx == 0)
				for (int c = 0; c < NDIMS; c++)
					pts[npoints][c] = '0;
			pts[npoints][cidx] = v;
		end else begin
			ovf = 1'b1;
		end
		if (last || cidx + 1 >= dims) begin
			cidx = 0;
			if (npoints < NPTS)
				npoints++;
		end else begin
			cidx++;
		end
		if (!last)
			return;
		r.threshold = '0;
		if (ovf) begin
			r.status = STAT_MANY;
		end else if (npoints < 2) begin
			r.status = STAT_FEW;
		end else begin
			r.status = STAT_OK;
			if (npoints <= PLIMIT) begin
				med = group_median(0, npoints, dims);
			end else begin
				parts = (npoints + PLIMIT) / PLIMIT;
				gsize = npoints / parts + 1;
				m = 0;
				for (int i = 0; i < parts; i++) begin
					lo = i * gsize;
					hi = (i + 1) * gsize;
					if (hi > npoints)
						hi = npoints;
					if (hi - lo >= 2) begin
						grp_med[m] = group_median(lo, hi, dims);
						m++;
					end
				end
				for (int i = 0; i < m; i++)
					work[i] = grp_med[i];
				med = m ? work_median(m) : 0;
			end
			prod = 64'(tau_reg) * 64'(med);
			r.threshold = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
		end
		if (typed_valid) begin
			r = typed_res;
			typed_valid = 1'b0;
		end
		pending_results.push_back(r);
		npoints = 0;
		cidx = 0;
		ovf = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TAU_GAIN)
					tau_reg = cfg_data[TAU_W-1:0];
				else if (cfg_index == CFG_DIMS_IN_USE)
					dims_reg = cfg_data[DIMS_W-1:0];
			end
			if (start && !busy)
				predict_coord(item.coord_value, item.last_point);
			if (result_valid) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result thr=%h status=%0d", result.threshold,
							result.status);
				end else begin
					if (result.threshold !== pending_results[0].threshold ||
							result.status !== pending_results[0].status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected thr=%h status=%0d, got thr=%h status=%0d",
								pending_results[0].threshold, pending_results[0].status,
								result.threshold, result.status);
					end
					void'(pending_results.pop_front());
				end
			end
		end
	end

	task automatic send_coord(input logic [COORD_W-1:0] v, input logic last);
		bit took;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= '{coord_value: v, last_point: last};
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
		items_sent++;
		if (last)
			sets_sent++;
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		bit took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_row(input int v, input int last);
		rows.push_back('{coord: v[15:0], last: last[0], typed: 1'b0, thr: '0, stat: STAT_OK});
	endtask

	task automatic random_set();
		int          n;
		int          dims;
		int          mode;
		int          ncoord;
		logic [15:0] same;
		logic [15:0] v;
		bit          lastc;
		n = $urandom_range(0, 99);
		if (n < 4)
			n = 1;
		else if (n < 8)
			n = $urandom_range(65, 68);
		else if (n < 20)
			n = $urandom_range(17, 64);
		else
			n = $urandom_range(2, 16);
		dims = (dims_reg == 0) ? 1 : (dims_reg > NDIMS) ? NDIMS : dims_reg;
		mode = $urandom_range(0, 3);
		same = 16'($urandom);
		for (int p = 0; p < n; p++) begin
			ncoord = dims;
			if (p == n - 1 && $urandom_range(0, 9) == 0)
				ncoord = $urandom_range(1, dims);
			for (int c = 0; c < ncoord; c++) begin
				case (mode)
					0: v = 16'($urandom);
					1: v = 16'($signed($urandom_range(0, 1024)) - 512);
					2: v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : same;
					default: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				endcase
				lastc = (p == n - 1) && (c == ncoord - 1);
				send_coord(v, lastc);
			end
		end
		if (n > NPTS)
			many_sets++;
		else if (n < 2)
			few_sets++;
	endtask

	initial begin
		logic [15:0] tau_list [7];
		logic [15:0] dims_list [7];
		row_t        rw;
		errors = 0;
		items_sent = 0;
		sets_sent = 0;
		few_sets = 0;
		many_sets = 0;
		results_seen = 0;
		typed_valid = 1'b0;
		npoints = 0;
		cidx = 0;
		ovf = 1'b0;
		tau_reg = TAU_RESET;
		dims_reg = DIMS_RESET;
		idle_pct = 30;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TAU_GAIN;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings: two coordinates per point, gain 256
		rows.push_back('{coord: 16'h0100, last: 1'b1, typed: 1'b1, thr: '0, stat: STAT_FEW});
		add_row(0, 0);
		add_row(0, 0);
		add_row(0, 0);
		rows.push_back('{coord: 16'h0000, last: 1'b1, typed: 1'b1, thr: '0, stat: STAT_OK});
		add_row(-32768, 0);
		add_row(-32768, 0);
		add_row(32767, 0);
		add_row(32767, 1);
		add_row('h0300, 0);
		add_row(-'h0400, 0);
		add_row(-'h0300, 0);
		add_row('h0400, 0);
		add_row('h7FFF, 1);
		add_row('h0001, 0);
		add_row('h0002, 0);
		add_row('h1234, 0);
		add_row(-'h1234, 0);
		add_row('h0000, 0);
		add_row('h5555, 0);
		add_row(-'h00FF, 0);
		add_row('h00FF, 1);
		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.typed) begin
				typed_res.threshold = rw.thr;
				typed_res.status = rw.stat;
				typed_valid = 1'b1;
			end
			send_coord(rw.coord, rw.last);
		end

		// too many points gives an error with zero threshold
		wait_quiet();
		for (int p = 0; p <= NPTS; p++)
			for (int c = 0; c < 2; c++) begin
				if (p == NPTS && c == 1) begin
					typed_res.threshold = '0;
					typed_res.status = STAT_MANY;
					typed_valid = 1'b1;
				end
				send_coord(16'($urandom), p == NPTS && c == 1);
			end
		many_sets++;

		// dimension count lowered while a point is half loaded
		wait_quiet();
		write_reg(CFG_DIMS_IN_USE, 16'd8);
		for (int c = 0; c < 5; c++)
			send_coord(16'($urandom), 1'b0);
		wait_quiet();
		write_reg(CFG_DIMS_IN_USE, 16'd2);
		send_coord(16'($urandom), 1'b0);
		send_coord(16'($urandom), 1'b0);
		send_coord(16'($urandom), 1'b1);

		tau_list  = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd513, 16'd65535, 16'd384};
		dims_list = '{16'd2, 16'd1, 16'd8, 16'd0, 16'd15, 16'd1, 16'd3};
		for (int ph = 0; ph < 7; ph++) begin
			wait_quiet();
			write_reg(CFG_TAU_GAIN, tau_list[ph]);
			write_reg(CFG_DIMS_IN_USE, dims_list[ph]);
			while (items_sent < (ph + 1) * NITEMS / 7) begin
				idle_pct = (items_sent < NITEMS / 3) ? 30 :
					(items_sent < 2 * NITEMS / 3) ? 85 : 0;
				random_set();
			end
		end

		wait_quiet();
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0)
			errors += pending_results.size();
		$display("sent %0d coordinates in %0d point sets (%0d too small, %0d too large)",
			items_sent, sets_sent, few_sets, many_sets);
		$display("checked %0d results over 7 gain and dimension settings, %0d errors",
			results_seen, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#200ms;
		$display("timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
